// ===== hw/rtl/ecc_pkg.sv =====
package ecc_pkg;

   localparam int COORD_WIDTH       = 24;
   localparam int DEFAULT_FRAC_BITS = 8;
   localparam int RADIUS_WIDTH      = 16;
   localparam int RADIUS_FRAC       = 8;
   localparam int UNIT_BITS         = 16;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_ax;
      logic signed [COORD_WIDTH-1:0] pos_ay;
      logic signed [COORD_WIDTH-1:0] vel_ax;
      logic signed [COORD_WIDTH-1:0] vel_ay;
      logic [RADIUS_WIDTH-1:0]       radius_a;
      logic signed [COORD_WIDTH-1:0] pos_bx;
      logic signed [COORD_WIDTH-1:0] pos_by;
      logic signed [COORD_WIDTH-1:0] vel_bx;
      logic signed [COORD_WIDTH-1:0] vel_by;
      logic [RADIUS_WIDTH-1:0]       radius_b;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [COORD_WIDTH-1:0] new_pos_ax;
      logic signed [COORD_WIDTH-1:0] new_pos_ay;
      logic signed [COORD_WIDTH-1:0] new_vel_ax;
      logic signed [COORD_WIDTH-1:0] new_vel_ay;
      logic signed [COORD_WIDTH-1:0] new_pos_bx;
      logic signed [COORD_WIDTH-1:0] new_pos_by;
      logic signed [COORD_WIDTH-1:0] new_vel_bx;
      logic signed [COORD_WIDTH-1:0] new_vel_by;
   } rsp_type;

endpackage

// ===== hw/rtl/elastic_circle_collision.sv =====
// Collision response for one pair of equal-mass circles per beat.
// The request channel (req_valid, req_ready, req_data) carries the position,
// velocity and radius of balls A and B. The response channel (rsp_valid,
// rsp_ready, rsp_data) returns the hit flag and both balls after the elastic
// impulse and the half-penetration push apart; a miss or coincident centers
// return the inputs unchanged. Results saturate to the coordinate width.
// The pipeline depth comes from the square root, which settles one root bit
// a stage, and the normal division, which settles one quotient bit a stage.
// One pair is taken every cycle while the response side keeps up.
// Each stage has its own valid bit and moves when the stage after it is empty
// or moving, so a stalled receiver fills the bubbles first and then holds
// req_ready low; nothing is dropped or repeated. Reset clears all valid bits
// and leaves the pipeline empty; the data registers are not reset.
module elastic_circle_collision
   import ecc_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW     = COORD_WIDTH;
   localparam int RAD_W  = RADIUS_WIDTH + FRAC_BITS - RADIUS_FRAC;
   localparam int SHL    = (FRAC_BITS >= RADIUS_FRAC) ? FRAC_BITS - RADIUS_FRAC : 0;
   localparam int SHR    = (FRAC_BITS >= RADIUS_FRAC) ? 0 : RADIUS_FRAC - FRAC_BITS;
   localparam int RSUM_W = RAD_W + 1;
   localparam int SQ_W   = RSUM_W + 1;
   localparam int REM_W  = SQ_W + 3;
   localparam int DIV_W  = SQ_W + 1;
   localparam int Q_W    = UNIT_BITS + 1;
   localparam int N_W    = Q_W + 1;
   localparam int RV_W   = CW + 1;
   localparam int PX_W   = RV_W + N_W;
   localparam int VS_W   = PX_W + 1;
   localparam int VN_W   = VS_W - UNIT_BITS;
   localparam int PEN_W  = SQ_W;
   localparam int CP_W   = N_W + PEN_W + 1;
   localparam int C_W    = CP_W - UNIT_BITS - 1;
   localparam int JP_W   = N_W + VN_W;
   localparam int J_W    = JP_W - UNIT_BITS;
   localparam int MAX_A  = (J_W > CW) ? J_W : CW;
   localparam int MAX_B  = (C_W > MAX_A) ? C_W : MAX_A;
   localparam int SUM_W  = MAX_B + 1;

   localparam int S_SQ0 = 4;
   localparam int S_DV0 = S_SQ0 + SQ_W;
   localparam int S_M1  = S_DV0 + Q_W;
   localparam int S_M2  = S_M1 + 1;
   localparam int S_M3  = S_M2 + 1;
   localparam int S_OUT = S_M3 + 1;
   localparam int NST   = S_OUT + 1;

   localparam logic signed [VS_W-1:0] VN_BIAS = VS_W'((1 << UNIT_BITS) - 1);
   localparam logic signed [CP_W-1:0] C_BIAS  = CP_W'((1 << (UNIT_BITS + 1)) - 1);
   localparam logic signed [JP_W-1:0] J_BIAS  = JP_W'((1 << UNIT_BITS) - 1);

   typedef struct packed {
      req_type                org;
      logic                   hit;
      logic                   act;
      logic                   sx;
      logic                   sy;
      logic [RSUM_W-1:0]      adx;
      logic [RSUM_W-1:0]      ady;
      logic [RSUM_W-1:0]      rsum;
      logic signed [RV_W-1:0] rvx;
      logic signed [RV_W-1:0] rvy;
   } ctx_type;

   // The value fits when all bits from the sign bit of the result up agree.
   function automatic logic signed [CW-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [CW-1:0] r;
      if ((&v[SUM_W-1:CW-1]) || !(|v[SUM_W-1:CW-1])) begin
         r = v[CW-1:0];
      end else if (v[SUM_W-1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

   // Handshake: a stage advances when it is empty or the next stage advances.
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;
   logic [NST-1:0] en;

   always_comb begin
      en[NST-1] = !valid_ff[NST-1] || rsp_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in = {valid_ff[NST-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = valid_ff[S_OUT];

   // Stage 0: input register.
   req_type s0_ff;
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= req_data;
      end
   end

   // Stage 1: differences, magnitudes and the bounding-box test.
   logic signed [CW:0] dx, dy;
   logic [CW:0]        adx_w, ady_w;
   logic [RAD_W-1:0]   ra, rb;
   logic [RSUM_W-1:0]  rsum;
   ctx_type            c1_in, c1_ff;

   always_comb begin
      if (FRAC_BITS >= RADIUS_FRAC) begin
         ra = RAD_W'(s0_ff.radius_a) << SHL;
         rb = RAD_W'(s0_ff.radius_b) << SHL;
      end else begin
         ra = RAD_W'(s0_ff.radius_a >> SHR);
         rb = RAD_W'(s0_ff.radius_b >> SHR);
      end
      rsum  = RSUM_W'(ra) + RSUM_W'(rb);
      dx    = RV_W'(s0_ff.pos_bx) - RV_W'(s0_ff.pos_ax);
      dy    = RV_W'(s0_ff.pos_by) - RV_W'(s0_ff.pos_ay);
      adx_w = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      ady_w = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      c1_in.org  = s0_ff;
      c1_in.hit  = (adx_w <= (CW+1)'(rsum)) && (ady_w <= (CW+1)'(rsum));
      c1_in.act  = 1'b0;
      c1_in.sx   = dx[CW];
      c1_in.sy   = dy[CW];
      c1_in.adx  = adx_w[RSUM_W-1:0];
      c1_in.ady  = ady_w[RSUM_W-1:0];
      c1_in.rsum = rsum;
      c1_in.rvx  = RV_W'(s0_ff.vel_bx) - RV_W'(s0_ff.vel_ax);
      c1_in.rvy  = RV_W'(s0_ff.vel_by) - RV_W'(s0_ff.vel_ay);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c1_ff <= c1_in;
      end
   end

   // Stage 2: squares.
   ctx_type             c2_ff;
   logic [2*RSUM_W-1:0] sqx_ff, sqy_ff, rsq_ff;
   always_ff @(posedge clock) begin
      if (en[2]) begin
         c2_ff  <= c1_ff;
         sqx_ff <= c1_ff.adx * c1_ff.adx;
         sqy_ff <= c1_ff.ady * c1_ff.ady;
         rsq_ff <= c1_ff.rsum * c1_ff.rsum;
      end
   end

   // Stage 3: squared distance and the overlap test.
   logic [2*RSUM_W:0] d2;
   ctx_type           c3_in, c3_ff;
   logic [2*SQ_W-1:0] rad3_ff;

   always_comb begin
      d2        = (2*RSUM_W+1)'(sqx_ff) + (2*RSUM_W+1)'(sqy_ff);
      c3_in     = c2_ff;
      c3_in.hit = c2_ff.hit && (d2 <= (2*RSUM_W+1)'(rsq_ff));
      c3_in.act = c3_in.hit && (d2 != '0);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         c3_ff   <= c3_in;
         rad3_ff <= (2*SQ_W)'(d2);
      end
   end

   // Square root, one root bit a stage.
   ctx_type          sq_ctx_ff  [SQ_W];
   logic [2*SQ_W-1:0] sq_x_ff   [SQ_W];
   logic [REM_W-1:0] sq_rem_ff  [SQ_W];
   logic [SQ_W-1:0]  sq_root_ff [SQ_W];

   for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
      ctx_type           c_i;
      logic [2*SQ_W-1:0] x_i;
      logic [REM_W-1:0]  rem_i, t, trial, rem_in;
      logic [SQ_W-1:0]   root_i, root_in;

      if (j == 0) begin : g_first
         assign c_i    = c3_ff;
         assign x_i    = rad3_ff;
         assign rem_i  = '0;
         assign root_i = '0;
      end else begin : g_next
         assign c_i    = sq_ctx_ff[j-1];
         assign x_i    = sq_x_ff[j-1];
         assign rem_i  = sq_rem_ff[j-1];
         assign root_i = sq_root_ff[j-1];
      end

      always_comb begin
         t     = {rem_i[REM_W-3:0], x_i[2*(SQ_W-1-j)+1 -: 2]};
         trial = REM_W'({root_i, 2'b01});
         if (t >= trial) begin
            rem_in  = t - trial;
            root_in = {root_i[SQ_W-2:0], 1'b1};
         end else begin
            rem_in  = t;
            root_in = {root_i[SQ_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_SQ0+j]) begin
            sq_ctx_ff[j]  <= c_i;
            sq_x_ff[j]    <= x_i;
            sq_rem_ff[j]  <= rem_in;
            sq_root_ff[j] <= root_in;
         end
      end
   end

   // Unit normal magnitudes: (|d| << UNIT_BITS) / dist, one quotient bit a stage.
   ctx_type          dv_ctx_ff  [Q_W];
   logic [SQ_W-1:0]  dv_dist_ff [Q_W];
   logic [DIV_W-1:0] dv_rx_ff   [Q_W];
   logic [DIV_W-1:0] dv_ry_ff   [Q_W];
   logic [Q_W-1:0]   dv_qx_ff   [Q_W];
   logic [Q_W-1:0]   dv_qy_ff   [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      ctx_type          c_i;
      logic [SQ_W-1:0]  dist_i;
      logic [DIV_W-1:0] rx_i, ry_i, tx, ty, rx_in, ry_in;
      logic [Q_W-1:0]   qx_i, qy_i, qx_in, qy_in;
      logic             nbx, nby;

      if (j == 0) begin : g_first
         assign c_i    = sq_ctx_ff[SQ_W-1];
         assign dist_i = sq_root_ff[SQ_W-1];
         assign rx_i   = DIV_W'(sq_ctx_ff[SQ_W-1].adx >> 1);
         assign ry_i   = DIV_W'(sq_ctx_ff[SQ_W-1].ady >> 1);
         assign qx_i   = '0;
         assign qy_i   = '0;
         assign nbx    = sq_ctx_ff[SQ_W-1].adx[0];
         assign nby    = sq_ctx_ff[SQ_W-1].ady[0];
      end else begin : g_next
         assign c_i    = dv_ctx_ff[j-1];
         assign dist_i = dv_dist_ff[j-1];
         assign rx_i   = dv_rx_ff[j-1];
         assign ry_i   = dv_ry_ff[j-1];
         assign qx_i   = dv_qx_ff[j-1];
         assign qy_i   = dv_qy_ff[j-1];
         assign nbx    = 1'b0;
         assign nby    = 1'b0;
      end

      always_comb begin
         tx = {rx_i[DIV_W-2:0], nbx};
         ty = {ry_i[DIV_W-2:0], nby};
         if (tx >= DIV_W'(dist_i)) begin
            rx_in = tx - DIV_W'(dist_i);
            qx_in = {qx_i[Q_W-2:0], 1'b1};
         end else begin
            rx_in = tx;
            qx_in = {qx_i[Q_W-2:0], 1'b0};
         end
         if (ty >= DIV_W'(dist_i)) begin
            ry_in = ty - DIV_W'(dist_i);
            qy_in = {qy_i[Q_W-2:0], 1'b1};
         end else begin
            ry_in = ty;
            qy_in = {qy_i[Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_DV0+j]) begin
            dv_ctx_ff[j]  <= c_i;
            dv_dist_ff[j] <= dist_i;
            dv_rx_ff[j]   <= rx_in;
            dv_ry_ff[j]   <= ry_in;
            dv_qx_ff[j]   <= qx_in;
            dv_qy_ff[j]   <= qy_in;
         end
      end
   end

   // M1: signed normal, penetration, relative velocity and push products.
   ctx_type                 dvc;
   logic signed [N_W-1:0]   nx, ny;
   logic [PEN_W-1:0]        pen;
   logic signed [PEN_W:0]   pen_s;
   ctx_type                 m1_ctx_ff;
   logic signed [N_W-1:0]   m1_nx_ff, m1_ny_ff;
   logic signed [PX_W-1:0]  m1_px_ff, m1_py_ff;
   logic signed [CP_W-1:0]  m1_cx_ff, m1_cy_ff;

   always_comb begin
      dvc   = dv_ctx_ff[Q_W-1];
      nx    = dvc.sx ? -N_W'(dv_qx_ff[Q_W-1]) : N_W'(dv_qx_ff[Q_W-1]);
      ny    = dvc.sy ? -N_W'(dv_qy_ff[Q_W-1]) : N_W'(dv_qy_ff[Q_W-1]);
      pen   = PEN_W'(dvc.rsum) - dv_dist_ff[Q_W-1];
      pen_s = {1'b0, pen};
   end

   always_ff @(posedge clock) begin
      if (en[S_M1]) begin
         m1_ctx_ff <= dvc;
         m1_nx_ff  <= nx;
         m1_ny_ff  <= ny;
         m1_px_ff  <= dvc.rvx * nx;
         m1_py_ff  <= dvc.rvy * ny;
         m1_cx_ff  <= nx * pen_s;
         m1_cy_ff  <= ny * pen_s;
      end
   end

   // M2: normal relative velocity and push amounts, truncated toward zero.
   logic signed [VS_W-1:0] vs, vsb;
   logic signed [CP_W-1:0] cxb, cyb;
   ctx_type                m2_ctx_ff;
   logic signed [N_W-1:0]  m2_nx_ff, m2_ny_ff;
   logic signed [VN_W-1:0] m2_vn_ff;
   logic signed [C_W-1:0]  m2_cx_ff, m2_cy_ff;

   always_comb begin
      vs  = VS_W'(m1_px_ff) + VS_W'(m1_py_ff);
      vsb = vs + (vs[VS_W-1] ? VN_BIAS : VS_W'(0));
      cxb = m1_cx_ff + (m1_cx_ff[CP_W-1] ? C_BIAS : CP_W'(0));
      cyb = m1_cy_ff + (m1_cy_ff[CP_W-1] ? C_BIAS : CP_W'(0));
   end

   always_ff @(posedge clock) begin
      if (en[S_M2]) begin
         m2_ctx_ff <= m1_ctx_ff;
         m2_nx_ff  <= m1_nx_ff;
         m2_ny_ff  <= m1_ny_ff;
         m2_vn_ff  <= vsb[VS_W-1:UNIT_BITS];
         m2_cx_ff  <= cxb[CP_W-1:UNIT_BITS+1];
         m2_cy_ff  <= cyb[CP_W-1:UNIT_BITS+1];
      end
   end

   // M3: impulse products.
   ctx_type                m3_ctx_ff;
   logic signed [JP_W-1:0] m3_jx_ff, m3_jy_ff;
   logic signed [C_W-1:0]  m3_cx_ff, m3_cy_ff;

   always_ff @(posedge clock) begin
      if (en[S_M3]) begin
         m3_ctx_ff <= m2_ctx_ff;
         m3_jx_ff  <= m2_nx_ff * m2_vn_ff;
         m3_jy_ff  <= m2_ny_ff * m2_vn_ff;
         m3_cx_ff  <= m2_cx_ff;
         m3_cy_ff  <= m2_cy_ff;
      end
   end

   // Output stage: impulse truncation, saturated sums and pass-through select.
   logic signed [JP_W-1:0]  jxb, jyb;
   logic signed [J_W-1:0]   jx, jy;
   logic signed [SUM_W-1:0] cxw, cyw, jxw, jyw;
   req_type                 o;
   rsp_type                 rsp_in, rsp_ff;

   always_comb begin
      o   = m3_ctx_ff.org;
      jxb = m3_jx_ff + (m3_jx_ff[JP_W-1] ? J_BIAS : JP_W'(0));
      jyb = m3_jy_ff + (m3_jy_ff[JP_W-1] ? J_BIAS : JP_W'(0));
      jx  = jxb[JP_W-1:UNIT_BITS];
      jy  = jyb[JP_W-1:UNIT_BITS];
      jxw = SUM_W'(jx);
      jyw = SUM_W'(jy);
      cxw = SUM_W'(m3_cx_ff);
      cyw = SUM_W'(m3_cy_ff);
      rsp_in.hit = m3_ctx_ff.hit;
      if (m3_ctx_ff.act) begin
         rsp_in.new_pos_ax = sat(SUM_W'(o.pos_ax) - cxw);
         rsp_in.new_pos_ay = sat(SUM_W'(o.pos_ay) - cyw);
         rsp_in.new_vel_ax = sat(SUM_W'(o.vel_ax) + jxw);
         rsp_in.new_vel_ay = sat(SUM_W'(o.vel_ay) + jyw);
         rsp_in.new_pos_bx = sat(SUM_W'(o.pos_bx) + cxw);
         rsp_in.new_pos_by = sat(SUM_W'(o.pos_by) + cyw);
         rsp_in.new_vel_bx = sat(SUM_W'(o.vel_bx) - jxw);
         rsp_in.new_vel_by = sat(SUM_W'(o.vel_by) - jyw);
      end else begin
         rsp_in.new_pos_ax = o.pos_ax;
         rsp_in.new_pos_ay = o.pos_ay;
         rsp_in.new_vel_ax = o.vel_ax;
         rsp_in.new_vel_ay = o.vel_ay;
         rsp_in.new_pos_bx = o.pos_bx;
         rsp_in.new_pos_by = o.pos_by;
         rsp_in.new_vel_bx = o.vel_bx;
         rsp_in.new_vel_by = o.vel_by;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== verif/elastic_circle_collision_test.sv =====
module elastic_circle_collision_test;
   import ecc_pkg::*;

   localparam int  HALF_PERIOD = 10;
   localparam int  PIPE_DEPTH  = RADIUS_WIDTH + DEFAULT_FRAC_BITS + UNIT_BITS + 3;
   localparam int  CYCLE_LIMIT = 400000;
   localparam longint COORD_MAX = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type expected_pairs[$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   bit      no_req_gaps = 1'b0;

   elastic_circle_collision dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] clamp(longint v);
      if (v > COORD_MAX) return COORD_MAX[COORD_WIDTH-1:0];
      if (v < COORD_MIN) return COORD_MIN[COORD_WIDTH-1:0];
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic longint align_radius(logic [RADIUS_WIDTH-1:0] r);
      if (DEFAULT_FRAC_BITS >= RADIUS_FRAC)
         return longint'(r) <<< (DEFAULT_FRAC_BITS - RADIUS_FRAC);
      return longint'(r) >>> (RADIUS_FRAC - DEFAULT_FRAC_BITS);
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Expected response of one pair: elastic impulse along the normal and a
   // half-penetration push apart, or a pass-through on a miss or coincident centers.
   function automatic rsp_type resolve_collision(req_type p);
      rsp_type r;
      longint  pax, pay, pbx, pby, vax, vay, vbx, vby;
      longint  rsum, dx, dy, unit, distance, nx, ny, vn, jx, jy, pen, cx, cy;
      longint unsigned d2;
      pax = p.pos_ax; pay = p.pos_ay; vax = p.vel_ax; vay = p.vel_ay;
      pbx = p.pos_bx; pby = p.pos_by; vbx = p.vel_bx; vby = p.vel_by;
      rsum = align_radius(p.radius_a) + align_radius(p.radius_b);
      dx = pbx - pax;
      dy = pby - pay;
      unit = longint'(1) <<< UNIT_BITS;
      r.hit = 1'b0;
      r.new_pos_ax = p.pos_ax; r.new_pos_ay = p.pos_ay;
      r.new_vel_ax = p.vel_ax; r.new_vel_ay = p.vel_ay;
      r.new_pos_bx = p.pos_bx; r.new_pos_by = p.pos_by;
      r.new_vel_bx = p.vel_bx; r.new_vel_by = p.vel_by;
      if (magnitude(dx) <= rsum && magnitude(dy) <= rsum) begin
         d2 = longint'(dx * dx) + longint'(dy * dy);
         if (d2 <= longint'(rsum * rsum)) begin
            r.hit = 1'b1;
            if (d2 != 0) begin
               distance = int_sqrt(d2);
               nx = (dx * unit) / distance;
               ny = (dy * unit) / distance;
               vn = ((vbx - vax) * nx + (vby - vay) * ny) / unit;
               jx = (nx * vn) / unit;
               jy = (ny * vn) / unit;
               pen = rsum - distance;
               cx = (nx * pen) / (unit * 2);
               cy = (ny * pen) / (unit * 2);
               r.new_vel_ax = clamp(vax + jx);
               r.new_vel_ay = clamp(vay + jy);
               r.new_vel_bx = clamp(vbx - jx);
               r.new_vel_by = clamp(vby - jy);
               r.new_pos_ax = clamp(pax - cx);
               r.new_pos_ay = clamp(pay - cy);
               r.new_pos_bx = clamp(pbx + cx);
               r.new_pos_by = clamp(pby + cy);
            end
         end
      end
      return r;
   endfunction

   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic send_pair(req_type p);
      int gap;
      gap = no_req_gaps ? 0 : gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      expected_pairs.push_back(resolve_collision(p));
   endtask

   task automatic check_field(string name, logic [COORD_WIDTH-1:0] exp_v,
                              logic [COORD_WIDTH-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // A beat is taken at the next rising edge; both sides change only there.
   always @(negedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pairs.size() == 0) begin
            $error("response beat with no pair outstanding");
            mismatch_count++;
         end else begin
            exp_r = expected_pairs.pop_front();
            check_field("hit", COORD_WIDTH'(exp_r.hit), COORD_WIDTH'(rsp_data.hit));
            check_field("new_pos_ax", exp_r.new_pos_ax, rsp_data.new_pos_ax);
            check_field("new_pos_ay", exp_r.new_pos_ay, rsp_data.new_pos_ay);
            check_field("new_vel_ax", exp_r.new_vel_ax, rsp_data.new_vel_ax);
            check_field("new_vel_ay", exp_r.new_vel_ay, rsp_data.new_vel_ay);
            check_field("new_pos_bx", exp_r.new_pos_bx, rsp_data.new_pos_bx);
            check_field("new_pos_by", exp_r.new_pos_by, rsp_data.new_pos_by);
            check_field("new_vel_bx", exp_r.new_vel_bx, rsp_data.new_vel_bx);
            check_field("new_vel_by", exp_r.new_vel_by, rsp_data.new_vel_by);
         end
      end
   end

   initial begin
      int run;
      wait (!reset);
      forever begin
         run = $urandom_range(1, 40);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
         rsp_ready <= 1'b0;
         repeat (run) @(posedge clock);
      end
   end

   task automatic finish_run(bit timed_out);
      if (!timed_out && mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("run did not finish within %0d cycles", CYCLE_LIMIT);
         finish_run(1'b1);
      end
   end

   function automatic req_type make_pair(longint pax, longint pay, longint vax, longint vay,
                                         int ra, longint pbx, longint pby, longint vbx,
                                         longint vby, int rb);
      req_type p;
      p.pos_ax = pax[COORD_WIDTH-1:0]; p.pos_ay = pay[COORD_WIDTH-1:0];
      p.vel_ax = vax[COORD_WIDTH-1:0]; p.vel_ay = vay[COORD_WIDTH-1:0];
      p.radius_a = ra[RADIUS_WIDTH-1:0];
      p.pos_bx = pbx[COORD_WIDTH-1:0]; p.pos_by = pby[COORD_WIDTH-1:0];
      p.vel_bx = vbx[COORD_WIDTH-1:0]; p.vel_by = vby[COORD_WIDTH-1:0];
      p.radius_b = rb[RADIUS_WIDTH-1:0];
      return p;
   endfunction

   task automatic test_directed();
      // Coincident centers, with zero and with full radii.
      send_pair(make_pair(100, 200, 5, -5, 0, 100, 200, -7, 7, 0));
      send_pair(make_pair(0, 0, COORD_MAX, COORD_MIN, 65535, 0, 0, 1, 1, 65535));
      // Touching along each axis and on a diagonal (3-4-5).
      send_pair(make_pair(0, 0, 256, 0, 256, 512, 0, -256, 0, 256));
      send_pair(make_pair(0, 0, 0, 256, 256, 0, -512, 0, -256, 256));
      send_pair(make_pair(0, 0, 300, 400, 768, 768, 1024, -300, -400, 512));
      // Just out of reach on x, then on y, then on a diagonal.
      send_pair(make_pair(0, 0, 1, 1, 256, 513, 0, 1, 1, 256));
      send_pair(make_pair(0, 0, 1, 1, 256, 0, 513, 1, 1, 256));
      send_pair(make_pair(0, 0, 1, 1, 256, 400, 400, 1, 1, 256));
      // Extreme velocities along the line of centers, so results reach the coordinate limits.
      send_pair(make_pair(0, 0, COORD_MAX, 0, 65535, 1000, 0, COORD_MIN, 0, 65535));
      send_pair(make_pair(0, 0, COORD_MIN, COORD_MIN, 65535, 700, 700, COORD_MAX,
                          COORD_MAX, 65535));
      // Deep overlap at the corners of the coordinate range pushes past the limit.
      send_pair(make_pair(COORD_MAX, COORD_MAX, 0, 0, 65535, COORD_MAX - 1,
                          COORD_MAX, 0, 0, 65535));
      send_pair(make_pair(COORD_MIN + 1, COORD_MIN, 0, 0, 65535, COORD_MIN,
                          COORD_MIN + 1, 0, 0, 65535));
      // Far apart at opposite extremes, and wrap-around distances.
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 65535, COORD_MAX,
                          COORD_MAX, COORD_MAX, COORD_MAX, 65535));
      send_pair(make_pair(COORD_MAX, 0, -1, -1, 0, COORD_MIN, 0, -1, -1, 0));
      // Zero radii with distinct centers, one unit apart.
      send_pair(make_pair(10, 10, 0, 0, 0, 11, 10, 0, 0, 0));
      // Separating balls still get the impulse.
      send_pair(make_pair(0, 0, -2560, 0, 512, 256, 0, 2560, 0, 512));
      // All bits set and all bits clear.
      send_pair('1);
      send_pair('0);
   endtask

   function automatic longint rand_coord();
      return longint'(signed'(COORD_WIDTH'($urandom)));
   endfunction

   function automatic longint rand_velocity();
      if ($urandom_range(0, 3) == 0) return rand_coord();
      return longint'($urandom_range(0, 8192)) - 4096;
   endfunction

   function automatic req_type near_pair();
      int     ra, rb;
      longint reach, pax, pay;
      longint dx, dy;
      ra = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
      rb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4096);
      reach = align_radius(RADIUS_WIDTH'(ra)) + align_radius(RADIUS_WIDTH'(rb));
      if ($urandom_range(0, 9) == 0) begin
         pax = rand_coord();
         pay = rand_coord();
      end else begin
         pax = longint'($urandom_range(0, 2000000)) - 1000000;
         pay = longint'($urandom_range(0, 2000000)) - 1000000;
      end
      dx = longint'($urandom_range(0, 2 * reach + 2)) - reach - 1;
      dy = longint'($urandom_range(0, 2 * reach + 2)) - reach - 1;
      return make_pair(pax, pay, rand_velocity(), rand_velocity(), ra,
                       pax + dx, pay + dy, rand_velocity(), rand_velocity(), rb);
   endfunction

   task automatic test_random_pairs(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_req_gaps = ($urandom_range(0, 3) == 0);
         send_pair(near_pair());
      end
      no_req_gaps = 1'b0;
   endtask

   task automatic test_random_noise(int count);
      req_type p;
      for (int i = 0; i < count; i++) begin
         p = make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       $urandom_range(0, 65535), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), $urandom_range(0, 65535));
         send_pair(p);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_pairs(1200);
      test_random_noise(250);
      req_valid <= 1'b0;
      wait (expected_pairs.size() == 0);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      finish_run(1'b0);
   end

endmodule
